### rtl/core/pgs_pkg.sv
// ============================================================================
// pgs_pkg
// Shared types, codes and keyword tables of the grayscale PAM stream parser.
// ============================================================================
package pgs_pkg;

    localparam int DIM_BITS_DEF = 16;
    localparam int NUM_MAX      = 65535;
    localparam int ACC_BITS     = 17;
    localparam int KW_COUNT     = 6;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_ACCEPT = 3'd1,
        KIND_PIXEL  = 3'd2,
        KIND_ERROR  = 3'd3,
        KIND_IGNORE = 3'd4
    } kind_t;

    // Parser phase, one-hot
    typedef enum logic [7:0] {
        PH_MAGIC  = 8'b0000_0001,
        PH_LEAD   = 8'b0000_0010,
        PH_KEY    = 8'b0000_0100,
        PH_VALUE  = 8'b0000_1000,
        PH_REST   = 8'b0001_0000,
        PH_PIXELS = 8'b0010_0000,
        PH_DONE   = 8'b0100_0000,
        PH_ERROR  = 8'b1000_0000
    } phase_t;

    // Keyword indexes
    localparam logic [2:0] KW_WIDTH  = 3'd0;
    localparam logic [2:0] KW_HEIGHT = 3'd1;
    localparam logic [2:0] KW_DEPTH  = 3'd2;
    localparam logic [2:0] KW_MAXVAL = 3'd3;
    localparam logic [2:0] KW_TUPL   = 3'd4;
    localparam logic [2:0] KW_END    = 3'd5;
    localparam logic [2:0] KW_NONE   = 3'd6;

    typedef logic [KW_COUNT-1:0] kw_mask_t;
    localparam kw_mask_t ALL_ALIVE = '1;

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd5, 4'd6, 4'd5, 4'd6, 4'd8, 4'd6};

    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"W", "I", "D", "T", "H", 8'h00, 8'h00, 8'h00},
        '{"H", "E", "I", "G", "H", "T", 8'h00, 8'h00},
        '{"D", "E", "P", "T", "H", 8'h00, 8'h00, 8'h00},
        '{"M", "A", "X", "V", "A", "L", 8'h00, 8'h00},
        '{"T", "U", "P", "L", "T", "Y", "P", "E"},
        '{"E", "N", "D", "H", "D", "R", 8'h00, 8'h00}
    };

    localparam logic [3:0] GRAY_LEN = 4'd9;
    localparam logic [7:0] GRAY_TEXT [16] = '{
        "G", "R", "A", "Y", "S", "C", "A", "L", "E",
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] CHAR_NL = 8'h0A;

    // Header parser state carried between bytes
    typedef struct packed {
        phase_t                phase;
        kw_mask_t              alive;
        logic [3:0]            char_pos;
        logic [ACC_BITS-1:0]   acc;
    } hdr_state_t;

    localparam hdr_state_t HDR_RESET = '{
        phase:    PH_MAGIC,
        alive:    ALL_ALIVE,
        char_pos: 4'd0,
        acc:      '0
    };

    localparam hdr_state_t HDR_NEW_LINE = '{
        phase:    PH_LEAD,
        alive:    ALL_ALIVE,
        char_pos: 4'd0,
        acc:      '0
    };

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) ||
               (c == 8'h0B) || (c == 8'h0C);
    endfunction

endpackage

### rtl/core/pgs_hdr.sv
// ============================================================================
// pgs_hdr
// Next-state logic of the PAM header parser for one byte.
// ============================================================================
module pgs_hdr #(
    parameter int DIM_BITS = pgs_pkg::DIM_BITS_DEF
) (
    input  logic [7:0]           data_byte,
    input  pgs_pkg::hdr_state_t  cur,
    input  logic [DIM_BITS-1:0]  width_cur,
    input  logic [DIM_BITS-1:0]  height_cur,
    output pgs_pkg::hdr_state_t  nxt,
    output logic [DIM_BITS-1:0]  width_next,
    output logic [DIM_BITS-1:0]  height_next,
    output pgs_pkg::kind_t       kind
);
    import pgs_pkg::*;

    localparam logic [19:0] DIM_LIMIT = 20'((64'd1 << DIM_BITS) - 64'd1);
    localparam logic [19:0] NUM_LIMIT = 20'(NUM_MAX);

    logic        nl;
    logic        ws;
    logic        digit;
    logic        err;
    logic [2:0]  match_idx;
    logic [2:0]  sel_idx;
    kw_mask_t    alive_step;
    logic [3:0]  pos_inc;
    logic [19:0] acc_wide;
    logic [19:0] acc_val;
    logic [19:0] limit;
    logic        gray_hit;

    assign nl    = (data_byte == CHAR_NL);
    assign ws    = is_space(data_byte);
    assign digit = (data_byte >= "0") && (data_byte <= "9");

    // Keyword lookup: fully matched keyword and first live keyword
    always_comb
    begin
        match_idx = KW_NONE;
        sel_idx   = KW_NONE;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (cur.alive[k] && (KW_LEN[k] == cur.char_pos))
                match_idx = 3'(k);
            if (cur.alive[k])
                sel_idx = 3'(k);
        end
    end

    // Drop keywords that no longer match the text so far
    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            alive_step[k] = cur.alive[k] && (cur.char_pos < KW_LEN[k]) &&
                            (KW_TEXT[k][cur.char_pos[2:0]] == data_byte);
        end
    end

    assign pos_inc  = (cur.char_pos == 4'd15) ? cur.char_pos : cur.char_pos + 4'd1;
    assign acc_wide = 20'(cur.acc);
    assign acc_val  = (acc_wide << 3) + (acc_wide << 1) + {16'd0, data_byte[3:0]};
    assign limit    = ((sel_idx == KW_WIDTH) || (sel_idx == KW_HEIGHT)) ? DIM_LIMIT
                                                                       : NUM_LIMIT;
    assign gray_hit = (cur.char_pos < GRAY_LEN) && (GRAY_TEXT[cur.char_pos] == data_byte);

    always_comb
    begin
        nxt         = cur;
        width_next  = width_cur;
        height_next = height_cur;
        kind        = KIND_HEADER;
        err         = 1'b0;

        unique case (cur.phase) inside
            PH_MAGIC:
            begin
                if (((cur.char_pos == 4'd0) && (data_byte == "P")) ||
                    ((cur.char_pos == 4'd1) && (data_byte == "7")))
                    nxt.char_pos = pos_inc;
                else if ((cur.char_pos == 4'd2) && nl)
                    nxt = HDR_NEW_LINE;
                else
                    err = 1'b1;
            end
            PH_LEAD, PH_KEY:
            begin
                if ((cur.phase == PH_LEAD) && ws)
                    nxt.alive[KW_END] = 1'b0;   // ENDHDR takes no indent
                else if ((cur.phase == PH_LEAD) && nl)
                    err = 1'b1;
                else if (ws || nl)
                begin
                    if ((match_idx == KW_END) && nl)
                    begin
                        nxt.phase = ((width_cur == '0) || (height_cur == '0)) ? PH_DONE
                                                                              : PH_PIXELS;
                        kind = KIND_ACCEPT;
                    end
                    else if ((match_idx == KW_END) || (match_idx == KW_NONE) || nl)
                        err = 1'b1;
                    else
                    begin
                        nxt.phase    = PH_VALUE;
                        nxt.alive    = '0;
                        nxt.alive[match_idx] = 1'b1;
                        nxt.char_pos = 4'd0;
                        nxt.acc      = '0;
                    end
                end
                else
                begin
                    nxt.phase    = PH_KEY;
                    nxt.alive    = alive_step;
                    nxt.char_pos = pos_inc;
                    if (alive_step == '0)
                        err = 1'b1;
                end
            end
            PH_VALUE:
            begin
                if ((cur.char_pos == 4'd0) && ws)
                    nxt = cur;
                else if (sel_idx == KW_TUPL)
                begin
                    if (ws || nl)
                    begin
                        if (cur.char_pos != GRAY_LEN)
                            err = 1'b1;
                        else if (nl)
                            nxt = HDR_NEW_LINE;
                        else
                            nxt.phase = PH_REST;
                    end
                    else if (gray_hit)
                        nxt.char_pos = pos_inc;
                    else
                        err = 1'b1;
                end
                else if (digit)
                begin
                    if (acc_val > limit)
                        err = 1'b1;
                    else
                    begin
                        nxt.acc      = acc_val[ACC_BITS-1:0];
                        nxt.char_pos = 4'd1;
                    end
                end
                else if (cur.char_pos == 4'd0)
                    err = 1'b1;
                else
                begin
                    unique case (sel_idx)
                        KW_WIDTH:  width_next  = cur.acc[DIM_BITS-1:0];
                        KW_HEIGHT: height_next = cur.acc[DIM_BITS-1:0];
                        KW_DEPTH:  err = (cur.acc != ACC_BITS'(1));
                        KW_MAXVAL: err = (cur.acc != ACC_BITS'(255));
                        default:   err = 1'b1;
                    endcase
                    if (nl)
                        nxt = HDR_NEW_LINE;
                    else
                        nxt.phase = PH_REST;
                end
            end
            PH_REST:
            begin
                if (nl)
                    nxt = HDR_NEW_LINE;
            end
            default:
                err = 1'b1;
        endcase

        if (err)
        begin
            nxt.phase = PH_ERROR;
            kind      = KIND_ERROR;
        end
    end

endmodule

### rtl/core/pam_grayscale_stream_parser.sv
// ============================================================================
// pam_grayscale_stream_parser
// Byte-serial parser for 8-bit grayscale PAM (P7) files with pixel tagging.
// ============================================================================
//
//  Channel | Beat contents                  | Handshake
//  --------+--------------------------------+------------------------------
//  in      | data_byte, file_start          | in_valid / in_stall
//  out     | kind, pixel, row, col,         | out_valid / out_stall
//          | img_width, img_height,         |
//          | last_pixel                     |
//
//  One input beat gives exactly one output beat, one beat per cycle sustained while out is not stalled.
//  Parsing of a byte is a single combinational step from the parser state
//  registers into the output register, or into the skid register while out is held.
//  A skid register behind the output register holds one result while out is
//  stalled, so in_stall rises only when that skid register is full.
//  Reset (rst_n, asynchronous) returns the parser to the magic-line phase with
//  no size known; file_start on a beat does the same before that byte is used.
//
module pam_grayscale_stream_parser #(
    parameter int DIM_BITS = pgs_pkg::DIM_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        file_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  pixel,
    output logic [15:0] row,
    output logic [15:0] col,
    output logic [15:0] img_width,
    output logic [15:0] img_height,
    output logic        last_pixel
);
    import pgs_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  pixel;
        logic [15:0] row;
        logic [15:0] col;
        logic [15:0] img_width;
        logic [15:0] img_height;
        logic        last;
    } res_t;

    // Parser state
    hdr_state_t          hdr_reg;
    hdr_state_t          hdr_next;
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] width_next;
    logic [DIM_BITS-1:0] height_reg;
    logic [DIM_BITS-1:0] height_next;
    logic [DIM_BITS-1:0] row_reg;
    logic [DIM_BITS-1:0] row_next;
    logic [DIM_BITS-1:0] col_reg;
    logic [DIM_BITS-1:0] col_next;

    // Output register and skid register
    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;

    // Current state after an optional file restart
    hdr_state_t          cur_hdr;
    logic [DIM_BITS-1:0] cur_width;
    logic [DIM_BITS-1:0] cur_height;
    logic [DIM_BITS-1:0] cur_row;
    logic [DIM_BITS-1:0] cur_col;

    hdr_state_t          parse_hdr;
    logic [DIM_BITS-1:0] parse_width;
    logic [DIM_BITS-1:0] parse_height;
    kind_t               parse_kind;

    logic [DIM_BITS:0]   col_inc;
    logic [DIM_BITS:0]   row_inc;
    logic                col_end;
    logic                row_end;

    res_t res_new;
    logic accept;
    logic out_fire;

    assign accept   = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    // A file start clears everything before the byte is looked at
    assign cur_hdr    = file_start ? HDR_RESET : hdr_reg;
    assign cur_width  = file_start ? '0 : width_reg;
    assign cur_height = file_start ? '0 : height_reg;
    assign cur_row    = file_start ? '0 : row_reg;
    assign cur_col    = file_start ? '0 : col_reg;

    pgs_hdr #(
        .DIM_BITS    (DIM_BITS)
    ) u_hdr (
        .data_byte   (data_byte),
        .cur         (cur_hdr),
        .width_cur   (cur_width),
        .height_cur  (cur_height),
        .nxt         (parse_hdr),
        .width_next  (parse_width),
        .height_next (parse_height),
        .kind        (parse_kind)
    );

    // Raster position: wrap the column at the width; the image ends after the last row
    assign col_inc = {1'b0, cur_col} + (DIM_BITS+1)'(1);
    assign row_inc = {1'b0, cur_row} + (DIM_BITS+1)'(1);
    assign col_end = (col_inc >= {1'b0, cur_width});
    assign row_end = (row_inc >= {1'b0, cur_height});

    always_comb
    begin
        hdr_next    = cur_hdr;
        width_next  = cur_width;
        height_next = cur_height;
        row_next    = cur_row;
        col_next    = cur_col;

        res_new.kind       = KIND_HEADER;
        res_new.pixel      = 8'd0;
        res_new.row        = 16'd0;
        res_new.col        = 16'd0;
        res_new.last       = 1'b0;

        unique case (cur_hdr.phase) inside
            PH_ERROR:
                res_new.kind = KIND_ERROR;
            PH_DONE:
                res_new.kind = KIND_IGNORE;
            PH_PIXELS:
            begin
                res_new.kind  = KIND_PIXEL;
                res_new.pixel = data_byte;
                res_new.row   = 16'(cur_row);
                res_new.col   = 16'(cur_col);
                if (col_end)
                begin
                    col_next = '0;
                    if (row_end)
                    begin
                        res_new.last   = 1'b1;
                        hdr_next.phase = PH_DONE;
                    end
                    else
                        row_next = row_inc[DIM_BITS-1:0];
                end
                else
                    col_next = col_inc[DIM_BITS-1:0];
            end
            default:
            begin
                hdr_next     = parse_hdr;
                width_next   = parse_width;
                height_next  = parse_height;
                res_new.kind = parse_kind;
                // Start the raster fresh when the header closes
                if (parse_kind == KIND_ACCEPT)
                begin
                    row_next = '0;
                    col_next = '0;
                end
            end
        endcase

        res_new.img_width  = 16'(width_next);
        res_new.img_height = 16'(height_next);
    end

    // Parser state advances on every accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg    <= HDR_RESET;
            width_reg  <= '0;
            height_reg <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else if (accept)
        begin
            hdr_reg    <= hdr_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

    // Output and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;     // skid drains into the output
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;     // output held, park the new result
        end
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    // Result payloads
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_fire)
                out_reg <= res_new;
            else
                skid_reg <= res_new;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_reg.kind;
    assign pixel      = out_reg.pixel;
    assign row        = out_reg.row;
    assign col        = out_reg.col;
    assign img_width  = out_reg.img_width;
    assign img_height = out_reg.img_height;
    assign last_pixel = out_reg.last;

endmodule

### rtl/core/pgs_checker.sv
// ============================================================================
// pgs_checker
// Port-level checks of the grayscale PAM stream parser, bound to the top.
// ============================================================================
module pgs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  kind,
    input logic [7:0]  pixel,
    input logic [15:0] row,
    input logic [15:0] col,
    input logic [15:0] img_width,
    input logic [15:0] img_height,
    input logic        last_pixel
);
    import pgs_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(pixel) &&
                                   $stable(row) && $stable(col) && $stable(last_pixel))
        else $error("stalled result beat changed");

    // Pixel fields stay zero outside pixel beats
    a_non_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_PIXEL) |->
            (pixel == 8'd0) && (row == 16'd0) && (col == 16'd0) && !last_pixel)
        else $error("pixel fields set on a non-pixel beat");

    // Pixel position lies inside the parsed image
    a_pixel_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_PIXEL) |-> (col < img_width) && (row < img_height))
        else $error("pixel position outside the image");

    // Last pixel sits at the bottom-right corner
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_pixel |->
            (kind == KIND_PIXEL) && (col == img_width - 16'd1) &&
            (row == img_height - 16'd1))
        else $error("last pixel not at the final position");

endmodule

bind pam_grayscale_stream_parser pgs_checker u_pgs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .pixel      (pixel),
    .row        (row),
    .col        (col),
    .img_width  (img_width),
    .img_height (img_height),
    .last_pixel (last_pixel)
);

### dv/tb.sv
// ============================================================================
// tb
// Self-checking bench for the grayscale PAM stream parser. A short table of
// hand-picked bytes opens the run, then randomly built PAM files follow:
// mostly well-formed headers in random line order with random spacing and
// small images, some with one injected header defect, some pure noise. Every
// accepted input beat is run through a bit-accurate parser model kept in the
// bench, and every output beat is checked against the oldest prediction.
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pgs_pkg::*;

    localparam int unsigned DIM_MAX     = (1 << DIM_BITS_DEF) - 1;
    localparam int unsigned VALUE_MAX   = 65535;
    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned BEAT_TARGET = 650;
    localparam logic [7:0]  LF          = 8'h0A;
    localparam logic [7:0]  BLANK [5]   = '{8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C};

    // One output beat as the parser presents it.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  pixel;
        logic [15:0] row;
        logic [15:0] col;
        logic [15:0] width;
        logic [15:0] height;
        logic        last;
    } beat_t;

    // Opening table row: a byte, its file-start flag and, where it is obvious,
    // the kind that must come back.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       pinned;
        kind_t      want;
    } opening_row_t;

    // Header defects that the file builder can inject.
    typedef enum int {
        FLT_NONE,
        FLT_BAD_MAGIC,
        FLT_FLIP,
        FLT_DEPTH,
        FLT_MAXVAL,
        FLT_BIG,
        FLT_SIGN,
        FLT_NOVAL,
        FLT_EMPTY,
        FLT_LEAD_END,
        FLT_TUPL,
        FLT_UNKNOWN,
        FLT_END_TAIL
    } fault_t;

    localparam opening_row_t OPENING [23] = '{
        '{"X",   1'b1, 1'b1, KIND_ERROR},   // bad magic right after reset
        '{8'hFF, 1'b0, 1'b1, KIND_ERROR},   // error holds
        '{"P",   1'b1, 1'b0, KIND_HEADER},  // file start clears the error
        '{"7",   1'b0, 1'b0, KIND_HEADER},
        '{LF,    1'b0, 1'b0, KIND_HEADER},
        '{LF,    1'b0, 1'b1, KIND_ERROR},   // empty keyword line
        '{"P",   1'b1, 1'b0, KIND_HEADER},  // header with no size at all
        '{"7",   1'b0, 1'b0, KIND_HEADER},
        '{LF,    1'b0, 1'b0, KIND_HEADER},
        '{"E",   1'b0, 1'b0, KIND_HEADER},
        '{"N",   1'b0, 1'b0, KIND_HEADER},
        '{"D",   1'b0, 1'b0, KIND_HEADER},
        '{"H",   1'b0, 1'b0, KIND_HEADER},
        '{"D",   1'b0, 1'b0, KIND_HEADER},
        '{"R",   1'b0, 1'b0, KIND_HEADER},
        '{LF,    1'b0, 1'b1, KIND_ACCEPT},
        '{8'h00, 1'b0, 1'b1, KIND_IGNORE},  // empty image: trailing bytes ignored
        '{8'hFF, 1'b0, 1'b1, KIND_IGNORE},
        '{"P",   1'b1, 1'b1, KIND_HEADER},
        '{"7",   1'b0, 1'b1, KIND_HEADER},
        '{LF,    1'b0, 1'b0, KIND_HEADER},
        '{8'h09, 1'b0, 1'b0, KIND_HEADER},  // whitespace before the end line
        '{"E",   1'b0, 1'b1, KIND_ERROR}
    };

    string KEYWORD [KW_COUNT] = '{"WIDTH", "HEIGHT", "DEPTH", "MAXVAL", "TUPLTYPE", "ENDHDR"};
    string GRAYSCALE_WORD     = "GRAYSCALE";

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        file_start;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  pixel;
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic        last_pixel;

    // Parser model state
    phase_t      ph;
    kw_mask_t    alive;
    logic [3:0]  cpos;
    int unsigned acc;
    int unsigned wreg;
    int unsigned hreg;
    int unsigned rcnt;
    int unsigned ccnt;

    beat_t       parsed_beats [$];
    logic [7:0]  file_bytes [$];
    int unsigned mismatches   = 0;
    int unsigned sent_beats   = 0;
    int unsigned burst_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_mode   = 0;
    int unsigned stall_span   = 0;
    int unsigned stall_tick   = 0;

    pam_grayscale_stream_parser DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .file_start (file_start),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .pixel      (pixel),
        .row        (row),
        .col        (col),
        .img_width  (img_width),
        .img_height (img_height),
        .last_pixel (last_pixel)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    function automatic logic blank(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic void fresh_line();
        ph    = PH_LEAD;
        alive = ALL_ALIVE;
        cpos  = 4'd0;
        acc   = 0;
    endfunction

    function automatic void restart_parser();
        ph    = PH_MAGIC;
        alive = ALL_ALIVE;
        cpos  = 4'd0;
        acc   = 0;
        wreg  = 0;
        hreg  = 0;
        rcnt  = 0;
        ccnt  = 0;
    endfunction

    // Kind of one header byte; every path that does not return success
    // drops into the error latch at the bottom.
    function automatic kind_t header_kind(logic [7:0] c);
        logic        nl;
        logic        ws;
        logic [2:0]  k;
        int unsigned v;
        int unsigned lim;

        nl = (c == LF);
        ws = blank(c);
        k  = KW_NONE;

        if (ph == PH_MAGIC)
        begin
            if ((cpos == 0 && c == "P") || (cpos == 1 && c == "7"))
            begin
                cpos++;
                return KIND_HEADER;
            end
            if (cpos == 2 && nl)
            begin
                fresh_line();
                return KIND_HEADER;
            end
        end
        else
        begin
            // Skip leading blanks; a blank rules out the end line.
            if (ph == PH_LEAD)
            begin
                if (ws)
                begin
                    alive[KW_END] = 1'b0;
                    return KIND_HEADER;
                end
                if (!nl)
                    ph = PH_KEY;
            end

            if (ph == PH_KEY)
            begin
                if (ws || nl)
                begin
                    for (int i = 0; i < KW_COUNT; i++)
                        if (k == KW_NONE && alive[i] && KEYWORD[i].len() == cpos)
                            k = 3'(i);
                    if (k == KW_END && nl)
                    begin
                        ph   = (wreg == 0 || hreg == 0) ? PH_DONE : PH_PIXELS;
                        rcnt = 0;
                        ccnt = 0;
                        return KIND_ACCEPT;
                    end
                    if (k != KW_END && k != KW_NONE && !nl)
                    begin
                        ph    = PH_VALUE;
                        alive = kw_mask_t'(1) << k;
                        cpos  = 4'd0;
                        acc   = 0;
                        return KIND_HEADER;
                    end
                end
                else
                begin
                    // Drop every keyword that this character rules out.
                    for (int i = 0; i < KW_COUNT; i++)
                        if (cpos >= KEYWORD[i].len() || KEYWORD[i][cpos] != c)
                            alive[i] = 1'b0;
                    if (cpos < 15)
                        cpos++;
                    if (alive != '0)
                        return KIND_HEADER;
                end
            end
            else if (ph == PH_VALUE)
            begin
                for (int i = KW_COUNT - 1; i >= 0; i--)
                    if (alive[i])
                        k = 3'(i);
                if (cpos == 0 && ws)
                    return KIND_HEADER;
                if (k == KW_TUPL)
                begin
                    if ((ws || nl) && cpos == GRAYSCALE_WORD.len())
                    begin
                        if (nl)
                            fresh_line();
                        else
                            ph = PH_REST;
                        return KIND_HEADER;
                    end
                    if (!ws && !nl && cpos < GRAYSCALE_WORD.len()
                            && GRAYSCALE_WORD[cpos] == c)
                    begin
                        cpos++;
                        return KIND_HEADER;
                    end
                end
                else if (c >= "0" && c <= "9")
                begin
                    lim = (k == KW_WIDTH || k == KW_HEIGHT) ? DIM_MAX : VALUE_MAX;
                    v   = acc * 10 + (c - "0");
                    if (v <= lim)
                    begin
                        acc  = v;
                        cpos = 4'd1;
                        return KIND_HEADER;
                    end
                end
                else if (cpos != 0 && (k == KW_WIDTH || k == KW_HEIGHT
                        || (k == KW_DEPTH && acc == 1) || (k == KW_MAXVAL && acc == 255)))
                begin
                    if (k == KW_WIDTH)
                        wreg = acc & DIM_MAX;
                    if (k == KW_HEIGHT)
                        hreg = acc & DIM_MAX;
                    if (nl)
                        fresh_line();
                    else
                        ph = PH_REST;
                    return KIND_HEADER;
                end
            end
            else if (ph == PH_REST)
            begin
                if (nl)
                    fresh_line();
                return KIND_HEADER;
            end
        end

        ph = PH_ERROR;
        return KIND_ERROR;
    endfunction

    // Advance the model by one input beat and return the beat it must give.
    function automatic beat_t parse_byte(logic [7:0] c, logic first);
        beat_t r;

        r = '0;
        if (first)
            restart_parser();

        if (ph == PH_ERROR)
        begin
            r.kind = KIND_ERROR;
        end
        else if (ph == PH_DONE)
        begin
            r.kind = KIND_IGNORE;
        end
        else if (ph == PH_PIXELS)
        begin
            r.kind  = KIND_PIXEL;
            r.pixel = c;
            r.row   = rcnt[15:0];
            r.col   = ccnt[15:0];
            if (ccnt + 1 >= wreg)
            begin
                ccnt = 0;
                if (rcnt + 1 >= hreg)
                begin
                    r.last = 1'b1;
                    ph     = PH_DONE;
                end
                else
                begin
                    rcnt++;
                end
            end
            else
            begin
                ccnt++;
            end
        end
        else
        begin
            r.kind = header_kind(c);
        end

        r.width  = wreg[15:0];
        r.height = hreg[15:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // File builder
    // ------------------------------------------------------------------------

    function automatic logic [7:0] blank_byte();
        return BLANK[$urandom_range(0, 4)];
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endfunction

    function automatic string number_text(int unsigned v);
        return ($urandom_range(0, 5) == 0) ? $sformatf("0%0d", v) : $sformatf("%0d", v);
    endfunction

    // Mostly tiny sizes so images finish; now and then the extremes.
    function automatic int unsigned pick_dim();
        int unsigned r;

        r = $urandom_range(0, 19);
        if (r < 16)
            return $urandom_range(0, 5);
        if (r < 18)
            return DIM_MAX;
        return $urandom_range(6, DIM_MAX);
    endfunction

    // Emit one keyword line with random leading blanks, spacing and tail.
    function automatic void put_keyword_line(string name, string value);
        if ($urandom_range(0, 7) == 0)
            file_bytes.push_back(blank_byte());
        put_str(name);
        if (value.len() != 0)
        begin
            repeat ($urandom_range(1, 2))
                file_bytes.push_back(blank_byte());
            put_str(value);
            if ($urandom_range(0, 3) == 0)
            begin
                file_bytes.push_back(blank_byte());
                put_str("#z");
            end
        end
        file_bytes.push_back(LF);
    endfunction

    function automatic void build_file();
        fault_t      fault;
        int unsigned w;
        int unsigned h;
        int unsigned npix;
        int unsigned t;
        int unsigned order [5];
        string       name;
        string       value;

        file_bytes.delete();

        // Pure noise now and then.
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(1, 24))
                file_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end

        fault = FLT_NONE;
        if ($urandom_range(0, 3) == 0)
            fault = fault_t'($urandom_range(FLT_BAD_MAGIC, FLT_END_TAIL));
        w = pick_dim();
        h = pick_dim();

        if (fault == FLT_BAD_MAGIC)
            put_str("P5\n");
        else
            put_str("P7\n");

        // Shuffle the five keyword lines.
        for (int i = 0; i < 5; i++)
            order[i] = i;
        for (int i = 4; i > 0; i--)
        begin
            t        = $urandom_range(0, i);
            {order[i], order[t]} = {order[t], order[i]};
        end

        foreach (order[j])
        begin
            case (order[j])
                0:
                begin
                    if (fault == FLT_UNKNOWN)
                        name = "WIDTHS";
                    else
                        name = "WIDTH";
                    value = number_text(w);
                    if (fault == FLT_NOVAL)
                        value = "";
                    else if (fault == FLT_BIG)
                        value = $sformatf("%0d", $urandom_range(DIM_MAX + 1, 999999));
                    else if (fault == FLT_SIGN)
                    begin
                        if ($urandom_range(0, 1) != 0)
                            value = {"-", value};
                        else
                            value = {"+", value};
                    end
                    if ($urandom_range(0, 11) != 0 || fault != FLT_NONE)
                        put_keyword_line(name, value);
                end
                1:
                begin
                    // Repeated HEIGHT: the later value must win.
                    if ($urandom_range(0, 9) == 0)
                        put_keyword_line("HEIGHT", number_text($urandom_range(0, 9)));
                    if ($urandom_range(0, 11) != 0 || fault != FLT_NONE)
                        put_keyword_line("HEIGHT", number_text(h));
                end
                2:
                begin
                    t = 1;
                    if (fault == FLT_DEPTH)
                        t = $urandom_range(0, 1) ? 0 : $urandom_range(2, 300);
                    put_keyword_line("DEPTH", number_text(t));
                end
                3:
                begin
                    t = 255;
                    if (fault == FLT_MAXVAL)
                        t = $urandom_range(0, 1) ? $urandom_range(0, 254)
                                                 : $urandom_range(256, VALUE_MAX);
                    put_keyword_line("MAXVAL", number_text(t));
                end
                default:
                begin
                    value = "GRAYSCALE";
                    if (fault == FLT_TUPL)
                    begin
                        t = $urandom_range(0, 2);
                        if (t == 0)
                            value = "GRAY";
                        else if (t == 1)
                            value = "GRAYSCALES";
                        else
                            value = "grayscale";
                    end
                    put_keyword_line("TUPLTYPE", value);
                end
            endcase
        end

        if (fault == FLT_EMPTY)
            file_bytes.push_back(LF);
        if (fault == FLT_LEAD_END)
            file_bytes.push_back(blank_byte());
        put_str("ENDHDR");
        if (fault == FLT_END_TAIL)
            file_bytes.push_back(blank_byte());
        file_bytes.push_back(LF);

        if (fault == FLT_FLIP)
        begin
            t = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[t] = file_bytes[t] ^ (8'd1 << $urandom_range(0, 7));
        end

        // Cut some files short in the middle of the header.
        if ($urandom_range(0, 9) == 0)
        begin
            t = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > t)
                void'(file_bytes.pop_back());
            return;
        end

        // Huge images get cut off by the next file start.
        npix = (w * h <= 64) ? w * h : $urandom_range(1, 40);
        if ($urandom_range(0, 9) == 0)
            npix = $urandom_range(0, npix);
        repeat (npix)
            file_bytes.push_back(8'($urandom_range(0, 255)));
        if (w * h <= 64)
            repeat ($urandom_range(0, 3))
                file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Present one beat, hold it until accepted, then record the prediction.
    // Idle gaps between bursts are inserted before the beat goes out.
    task automatic send_byte(logic [7:0] b, logic first, logic pinned, kind_t want);
        beat_t exp_beat;

        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7))
                @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        else
        begin
            burst_left--;
        end

        in_valid   <= 1'b1;
        data_byte  <= b;
        file_start <= first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);

        exp_beat = parse_byte(b, first);
        sent_beats++;
        if (pinned)
            exp_beat.kind = want;
        parsed_beats.push_back(exp_beat);
    endtask

    initial
    begin
        int unsigned files;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        data_byte  <= 8'h00;
        file_start <= 1'b0;
        restart_parser();
        files = 0;

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hand-picked opening: reset state, byte extremes, error latch.
        foreach (OPENING[i])
            send_byte(OPENING[i].data, OPENING[i].first, OPENING[i].pinned, OPENING[i].want);

        // Random files until enough beats have gone through.
        while (sent_beats < BEAT_TARGET)
        begin
            build_file();
            foreach (file_bytes[j])
                send_byte(file_bytes[j], j == 0, 1'b0, KIND_HEADER);
            files++;
            // Hold off once and let the parser drain completely.
            if (files == 2)
            begin
                in_valid <= 1'b0;
                while (parsed_beats.size() != 0)
                    @(posedge clk);
            end
        end

        in_valid <= 1'b0;
        while (parsed_beats.size() != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall in stretches of changing character
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(16, 96);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (stall_tick[1:0] == 2'b11);
        endcase
    end

    // ------------------------------------------------------------------------
    // Output check
    // ------------------------------------------------------------------------

    function automatic string beat_text(beat_t b);
        return $sformatf("kind=%0d pixel=%0d row=%0d col=%0d w=%0d h=%0d last=%0b",
                         b.kind, b.pixel, b.row, b.col, b.width, b.height, b.last);
    endfunction

    // Compare each accepted output beat with the oldest prediction.
    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            got = {kind_t'(kind), pixel, row, col, img_width, img_height, last_pixel};
            if (parsed_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat with nothing pending: %s", beat_text(got));
            end
            else
            begin
                want = parsed_beats.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat mismatch: expected %s, got %s",
                                 beat_text(want), beat_text(got));
                end
            end
        end
    end

    // Abort when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

### filelist.f
rtl/core/pgs_pkg.sv
rtl/core/pgs_hdr.sv
rtl/core/pam_grayscale_stream_parser.sv
rtl/core/pgs_checker.sv
dv/tb.sv
